// File: rtl/tta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_pkg: shared types and constants of the texture transform animator
// Fixed-point constants, series coefficient tables, command and status types.
// ----------------------------------------------------------------------------
package tta_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_STEPS  = 33;

    localparam logic [31:0] Q16_ONE     = 32'd65536;
    localparam logic [31:0] Q16_HALF    = 32'd32768;
    localparam logic [31:0] Q30_ONE     = 32'd1073741824;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [2:0]  SER_LAST    = 3'd5;
    localparam logic [3:0]  ROT_TERMS   = 4'd12;

    typedef enum logic [2:0] {
        CFG_U_SCALE       = 3'd0,
        CFG_V_SCALE       = 3'd1,
        CFG_U_SCROLL_RATE = 3'd2,
        CFG_V_SCROLL_RATE = 3'd3,
        CFG_SCROLL_ENABLE = 3'd4,
        CFG_ROTATE_RATE   = 3'd5
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCRU,
        ST_SCRV,
        ST_ANG,
        ST_ANGW,
        ST_X,
        ST_XW,
        ST_X2,
        ST_X2W,
        ST_SA,
        ST_SB,
        ST_SC,
        ST_SIN,
        ST_SINW,
        ST_FOLD,
        ST_WAITDIV,
        ST_ROT,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        MS_NONE,
        MS_SCROLL_U,
        MS_SCROLL_V,
        MS_ANGLE,
        MS_X,
        MS_X2,
        MS_SER_A,
        MS_SER_B,
        MS_SIN,
        MS_ROT
    } mul_sel_t;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_SCROLL_U,
        WB_SCROLL_V,
        WB_ANGLE,
        WB_X,
        WB_X2,
        WB_SER_B,
        WB_SER_C,
        WB_SIN,
        WB_FOLD,
        WB_ROT,
        WB_OUT
    } wb_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        mul_sel_t mul_sel;
        wb_sel_t  wb_sel;
        logic [3:0] idx;
        logic     cos_phase;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_valid;
    } dp_status_t;

    function automatic logic [7:0] ser_k(input logic cos_sel, input logic [2:0] i);
        logic [7:0] k;
        case (i)
            3'd0:    k = cos_sel ? 8'd132 : 8'd156;
            3'd1:    k = cos_sel ? 8'd90  : 8'd110;
            3'd2:    k = cos_sel ? 8'd56  : 8'd72;
            3'd3:    k = cos_sel ? 8'd30  : 8'd42;
            3'd4:    k = cos_sel ? 8'd12  : 8'd20;
            default: k = cos_sel ? 8'd2   : 8'd6;
        endcase
        return k;
    endfunction

    // floor(2^32 / k) for each series coefficient
    function automatic logic [31:0] ser_m(input logic cos_sel, input logic [2:0] i);
        logic [31:0] m;
        case (i)
            3'd0:    m = cos_sel ? 32'd32537631  : 32'd27531841;
            3'd1:    m = cos_sel ? 32'd47721858  : 32'd39045157;
            3'd2:    m = cos_sel ? 32'd76695844  : 32'd59652323;
            3'd3:    m = cos_sel ? 32'd143165576 : 32'd102261126;
            3'd4:    m = cos_sel ? 32'd357913941 : 32'd214748364;
            default: m = cos_sel ? 32'd2147483648 : 32'd715827882;
        endcase
        return m;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -52'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] rnd16_sat(input logic signed [51:0] v);
        logic signed [51:0] w;
        w = (v + 52'sd32768) >>> 16;
        return sat32(w);
    endfunction

endpackage

// File: rtl/tta_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_ifs: channel interfaces of the texture transform animator
// Tick channel carries one time delta; matrix channel carries one 2x3 matrix.
// ----------------------------------------------------------------------------
interface tta_tick_if;
    logic        valid;
    logic        ready;
    logic [23:0] time_delta;

    modport source (output valid, output time_delta, input ready);
    modport sink   (input valid, input time_delta, output ready);
endinterface

interface tta_mat_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m03;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m13;

    modport source (output valid, output m00, output m01, output m03,
                    output m10, output m11, output m13, input ready);
    modport sink   (input valid, input m00, input m01, input m03,
                    input m10, input m11, input m13, output ready);
endinterface

// File: rtl/tta_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_recip: reciprocal scale unit
// Restoring divider, one quotient bit per cycle, U scale then V scale.
// ----------------------------------------------------------------------------
module tta_recip (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [23:0]        u_scale,
    input  logic [23:0]        v_scale,
    output logic signed [31:0] recip_u,
    output logic signed [31:0] recip_v,
    output logic               done
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        sel_reg, sel_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [24:0] rem_reg, rem_next;
    logic [32:0] dq_reg, dq_next;
    logic signed [31:0] ru_reg, ru_next;
    logic signed [31:0] rv_reg, rv_next;

    logic [23:0] divisor;
    logic [24:0] rem_sh;
    logic        ge;
    logic [32:0] quot;
    logic signed [31:0] q_sat;

    always_comb
    begin
        divisor = sel_reg ? v_scale : u_scale;
        rem_sh  = {rem_reg[23:0], dq_reg[32]};
        ge      = rem_sh >= {1'b0, divisor};
        quot    = {dq_reg[31:0], ge};
        if (quot[32:31] != 2'b00 || divisor == 24'd0)
            q_sat = 32'sh7FFFFFFF;
        else
            q_sat = $signed({1'b0, quot[30:0]});

        busy_next = busy_reg;
        done_next = done_reg;
        sel_next  = sel_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        ru_next   = ru_reg;
        rv_next   = rv_reg;

        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            sel_next  = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = {1'b1, 32'd0} + 33'(u_scale >> 1);
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
            dq_next  = quot;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(tta_pkg::DIV_STEPS - 1))
            begin
                cnt_next = '0;
                rem_next = '0;
                if (!sel_reg)
                begin
                    ru_next  = q_sat;
                    sel_next = 1'b1;
                    dq_next  = {1'b1, 32'd0} + 33'(v_scale >> 1);
                end
                else
                begin
                    rv_next   = q_sat;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sel_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            sel_reg  <= sel_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        ru_reg  <= ru_next;
        rv_reg  <= rv_next;
    end

    assign recip_u = ru_reg;
    assign recip_v = rv_reg;
    assign done    = done_reg;

endmodule

// File: rtl/tta_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_datapath: registers, shared multiplier and matrix arithmetic
// Holds configuration and animation state; executes controller commands.
// ----------------------------------------------------------------------------
module tta_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tta_pkg::dp_cmd_t           cmd,
    output tta_pkg::dp_status_t        status,
    input  logic                       cfg_we,
    input  logic [tta_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tta_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [23:0]                time_delta,
    input  logic                       out_ready,
    output logic signed [31:0]         m00,
    output logic signed [31:0]         m01,
    output logic signed [31:0]         m03,
    output logic signed [31:0]         m10,
    output logic signed [31:0]         m11,
    output logic signed [31:0]         m13
);

    localparam int AB = tta_pkg::ANGLE_BITS;

    logic [23:0]        u_scale_reg, v_scale_reg;
    logic signed [31:0] u_rate_reg, v_rate_reg, rot_rate_reg;
    logic               scroll_en_reg;

    logic signed [31:0] u_off_reg, v_off_reg;
    logic [AB-1:0]      angle_reg;

    logic [23:0]        dt_reg;
    logic signed [65:0] prod_reg;
    logic [30:0]        x_reg;
    logic [31:0]        x2_reg;
    logic signed [31:0] t_reg;
    logic [31:0]        mq_reg;
    logic [30:0]        s_raw_reg;
    logic signed [17:0] sin_reg, cos_reg;
    logic signed [51:0] acc_reg;
    logic signed [31:0] res_reg [6];
    logic signed [31:0] out_reg [6];
    logic               out_valid_reg;

    logic signed [31:0] recip_u, recip_v;
    logic               div_done;

    logic signed [32:0] mul_a, mul_b;
    logic [31:0]        p_word;
    logic signed [31:0] pm [2][3];

    logic [3:0]         k_idx, w_idx;
    logic [2:0]         ko, wo;
    logic [1:0]         kcol;
    logic               krow;

    logic signed [41:0] u_inc, v_inc;
    logic [31:0]        q_est;
    logic [39:0]        kq;
    logic [39:0]        rem_c;
    logic [32:0]        q_fix;
    logic signed [33:0] t_calc;
    logic [31:0]        s_rnd;
    logic signed [31:0] c_rnd;
    logic signed [17:0] s16, c16;
    logic signed [19:0] tx_sum, ty_sum;
    logic signed [51:0] tx, ty, init_w, prod52;
    logic [7:0]         kc;

    tta_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .u_scale (u_scale_reg),
        .v_scale (v_scale_reg),
        .recip_u (recip_u),
        .recip_v (recip_v),
        .done    (div_done)
    );

    always_comb
    begin
        p_word = {angle_reg, {(32-AB){1'b0}}};

        pm[0][0] = recip_u;
        pm[0][1] = '0;
        pm[0][2] = scroll_en_reg ? u_off_reg : $signed(tta_pkg::Q16_HALF) - (recip_u >>> 1);
        pm[1][0] = '0;
        pm[1][1] = recip_v;
        pm[1][2] = scroll_en_reg ? v_off_reg : $signed(tta_pkg::Q16_HALF) - (recip_v >>> 1);

        k_idx = cmd.idx;
        ko    = k_idx[3:1];
        krow  = ko >= 3'd3;
        kcol  = krow ? 2'(ko - 3'd3) : ko[1:0];

        case (cmd.mul_sel)
            tta_pkg::MS_SCROLL_U:
            begin
                mul_a = 33'(u_rate_reg);
                mul_b = $signed({9'd0, dt_reg});
            end
            tta_pkg::MS_SCROLL_V:
            begin
                mul_a = 33'(v_rate_reg);
                mul_b = $signed({9'd0, dt_reg});
            end
            tta_pkg::MS_ANGLE:
            begin
                mul_a = 33'(rot_rate_reg);
                mul_b = $signed({9'd0, dt_reg});
            end
            tta_pkg::MS_X:
            begin
                mul_a = $signed({3'd0, p_word[29:0]});
                mul_b = $signed({2'd0, tta_pkg::HALF_PI_Q30});
            end
            tta_pkg::MS_X2:
            begin
                mul_a = $signed({2'd0, x_reg});
                mul_b = $signed({2'd0, x_reg});
            end
            tta_pkg::MS_SER_A:
            begin
                mul_a = $signed({1'b0, x2_reg});
                mul_b = 33'(t_reg);
            end
            tta_pkg::MS_SER_B:
            begin
                mul_a = $signed({1'b0, prod_reg[61:30]});
                mul_b = $signed({1'b0, tta_pkg::ser_m(cmd.cos_phase, cmd.idx[2:0])});
            end
            tta_pkg::MS_SIN:
            begin
                mul_a = $signed({2'd0, x_reg});
                mul_b = 33'(t_reg);
            end
            tta_pkg::MS_ROT:
            begin
                if (!krow)
                    mul_a = k_idx[0] ? 33'(-sin_reg) : 33'(cos_reg);
                else
                    mul_a = k_idx[0] ? 33'(cos_reg) : 33'(sin_reg);
                mul_b = 33'(pm[k_idx[0]][kcol]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        u_inc  = 42'($signed(prod_reg[56:16]));
        v_inc  = u_inc;

        kc     = tta_pkg::ser_k(cmd.cos_phase, cmd.idx[2:0]);
        q_est  = prod_reg[63:32];
        kq     = 40'(q_est) * 40'(kc);
        rem_c  = 40'(mq_reg) - kq;
        q_fix  = 33'(q_est) + 33'(rem_c >= 40'(kc));
        t_calc = $signed(34'(tta_pkg::Q30_ONE)) - $signed({1'b0, q_fix});

        s_rnd  = (32'(s_raw_reg) + 32'd8192) >> 14;
        c_rnd  = (t_reg + 32'sd8192) >>> 14;

        case (p_word[31:30])
            2'd0:
            begin
                s16 = $signed(s_rnd[17:0]);
                c16 = c_rnd[17:0];
            end
            2'd1:
            begin
                s16 = c_rnd[17:0];
                c16 = -$signed(s_rnd[17:0]);
            end
            2'd2:
            begin
                s16 = -$signed(s_rnd[17:0]);
                c16 = -c_rnd[17:0];
            end
            default:
            begin
                s16 = -c_rnd[17:0];
                c16 = $signed(s_rnd[17:0]);
            end
        endcase

        tx_sum = $signed(20'(tta_pkg::Q16_ONE)) - 20'(cos_reg) + 20'(sin_reg);
        ty_sum = $signed(20'(tta_pkg::Q16_ONE)) - 20'(sin_reg) - 20'(cos_reg);
        tx     = 52'(tx_sum) <<< 15;
        ty     = 52'(ty_sum) <<< 15;

        w_idx  = cmd.idx - 4'd1;
        wo     = w_idx[3:1];
        if (wo == 3'd2)
            init_w = tx;
        else if (wo == 3'd5)
            init_w = ty;
        else
            init_w = '0;
        prod52 = prod_reg[51:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_scale_reg   <= 24'(tta_pkg::Q16_ONE);
            v_scale_reg   <= 24'(tta_pkg::Q16_ONE);
            u_rate_reg    <= '0;
            v_rate_reg    <= '0;
            scroll_en_reg <= 1'b0;
            rot_rate_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tta_pkg::CFG_U_SCALE:       u_scale_reg   <= cfg_data[23:0];
                tta_pkg::CFG_V_SCALE:       v_scale_reg   <= cfg_data[23:0];
                tta_pkg::CFG_U_SCROLL_RATE: u_rate_reg    <= $signed(cfg_data);
                tta_pkg::CFG_V_SCROLL_RATE: v_rate_reg    <= $signed(cfg_data);
                tta_pkg::CFG_SCROLL_ENABLE: scroll_en_reg <= cfg_data[0];
                tta_pkg::CFG_ROTATE_RATE:   rot_rate_reg  <= $signed(cfg_data);
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_off_reg     <= '0;
            v_off_reg     <= '0;
            angle_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wb_sel == tta_pkg::WB_SCROLL_U && scroll_en_reg)
                u_off_reg <= tta_pkg::sat32(52'(u_off_reg) + 52'(u_inc));
            if (cmd.wb_sel == tta_pkg::WB_SCROLL_V && scroll_en_reg)
                v_off_reg <= tta_pkg::sat32(52'(v_off_reg) + 52'(v_inc));
            if (cmd.wb_sel == tta_pkg::WB_ANGLE)
                angle_reg <= angle_reg + prod_reg[32-AB +: AB];
            if (cmd.wb_sel == tta_pkg::WB_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load)
            dt_reg <= time_delta;
        case (cmd.wb_sel)
            tta_pkg::WB_X:
            begin
                x_reg <= prod_reg[60:30];
                t_reg <= $signed(tta_pkg::Q30_ONE);
            end
            tta_pkg::WB_X2:    x2_reg <= prod_reg[61:30];
            tta_pkg::WB_SER_B: mq_reg <= prod_reg[61:30];
            tta_pkg::WB_SER_C: t_reg  <= t_calc[31:0];
            tta_pkg::WB_SIN:
            begin
                s_raw_reg <= prod_reg[60:30];
                t_reg     <= $signed(tta_pkg::Q30_ONE);
            end
            tta_pkg::WB_FOLD:
            begin
                sin_reg <= s16;
                cos_reg <= c16;
            end
            tta_pkg::WB_ROT:
            begin
                if (!w_idx[0])
                    acc_reg <= init_w + prod52;
                else
                    res_reg[wo] <= tta_pkg::rnd16_sat(acc_reg + prod52);
            end
            tta_pkg::WB_OUT:
            begin
                if (rot_rate_reg != 32'sd0)
                begin
                    for (int i = 0; i < 6; i++)
                        out_reg[i] <= res_reg[i];
                end
                else
                begin
                    out_reg[0] <= pm[0][0];
                    out_reg[1] <= pm[0][1];
                    out_reg[2] <= pm[0][2];
                    out_reg[3] <= pm[1][0];
                    out_reg[4] <= pm[1][1];
                    out_reg[5] <= pm[1][2];
                end
            end
            default: ;
        endcase
    end

    assign m00 = out_reg[0];
    assign m01 = out_reg[1];
    assign m03 = out_reg[2];
    assign m10 = out_reg[3];
    assign m11 = out_reg[4];
    assign m13 = out_reg[5];

    assign status.div_done  = div_done;
    assign status.out_valid = out_valid_reg;

endmodule

// File: rtl/tta_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_ctrl: sequencer of the texture transform animator
// Steps the datapath through scroll, angle, sine/cosine series and rotation.
// ----------------------------------------------------------------------------
module tta_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    input  tta_pkg::dp_status_t status,
    output tta_pkg::dp_cmd_t    cmd
);

    tta_pkg::state_t state_reg, state_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic            cos_reg, cos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tta_pkg::ST_IDLE;
            cnt_reg   <= '0;
            cos_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cos_reg   <= cos_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cos_next      = cos_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.mul_sel   = tta_pkg::MS_NONE;
        cmd.wb_sel    = tta_pkg::WB_NONE;
        cmd.idx       = cnt_reg;
        cmd.cos_phase = cos_reg;

        case (state_reg)
            tta_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    cos_next      = 1'b0;
                    state_next    = tta_pkg::ST_SCRU;
                end
            end
            tta_pkg::ST_SCRU:
            begin
                cmd.mul_sel = tta_pkg::MS_SCROLL_U;
                state_next  = tta_pkg::ST_SCRV;
            end
            tta_pkg::ST_SCRV:
            begin
                cmd.mul_sel = tta_pkg::MS_SCROLL_V;
                cmd.wb_sel  = tta_pkg::WB_SCROLL_U;
                state_next  = tta_pkg::ST_ANG;
            end
            tta_pkg::ST_ANG:
            begin
                cmd.mul_sel = tta_pkg::MS_ANGLE;
                cmd.wb_sel  = tta_pkg::WB_SCROLL_V;
                state_next  = tta_pkg::ST_ANGW;
            end
            tta_pkg::ST_ANGW:
            begin
                cmd.wb_sel = tta_pkg::WB_ANGLE;
                state_next = tta_pkg::ST_X;
            end
            tta_pkg::ST_X:
            begin
                cmd.mul_sel = tta_pkg::MS_X;
                state_next  = tta_pkg::ST_XW;
            end
            tta_pkg::ST_XW:
            begin
                cmd.wb_sel = tta_pkg::WB_X;
                state_next = tta_pkg::ST_X2;
            end
            tta_pkg::ST_X2:
            begin
                cmd.mul_sel = tta_pkg::MS_X2;
                state_next  = tta_pkg::ST_X2W;
            end
            tta_pkg::ST_X2W:
            begin
                cmd.wb_sel = tta_pkg::WB_X2;
                state_next = tta_pkg::ST_SA;
            end
            tta_pkg::ST_SA:
            begin
                cmd.mul_sel = tta_pkg::MS_SER_A;
                state_next  = tta_pkg::ST_SB;
            end
            tta_pkg::ST_SB:
            begin
                cmd.mul_sel = tta_pkg::MS_SER_B;
                cmd.wb_sel  = tta_pkg::WB_SER_B;
                state_next  = tta_pkg::ST_SC;
            end
            tta_pkg::ST_SC:
            begin
                cmd.wb_sel = tta_pkg::WB_SER_C;
                if (cnt_reg[2:0] == tta_pkg::SER_LAST)
                begin
                    cnt_next   = '0;
                    state_next = cos_reg ? tta_pkg::ST_FOLD : tta_pkg::ST_SIN;
                end
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = tta_pkg::ST_SA;
                end
            end
            tta_pkg::ST_SIN:
            begin
                cmd.mul_sel = tta_pkg::MS_SIN;
                state_next  = tta_pkg::ST_SINW;
            end
            tta_pkg::ST_SINW:
            begin
                cmd.wb_sel = tta_pkg::WB_SIN;
                cos_next   = 1'b1;
                state_next = tta_pkg::ST_SA;
            end
            tta_pkg::ST_FOLD:
            begin
                cmd.wb_sel = tta_pkg::WB_FOLD;
                state_next = tta_pkg::ST_WAITDIV;
            end
            tta_pkg::ST_WAITDIV:
            begin
                if (status.div_done)
                    state_next = tta_pkg::ST_ROT;
            end
            tta_pkg::ST_ROT:
            begin
                if (cnt_reg != tta_pkg::ROT_TERMS)
                    cmd.mul_sel = tta_pkg::MS_ROT;
                if (cnt_reg != 4'd0)
                    cmd.wb_sel = tta_pkg::WB_ROT;
                if (cnt_reg == tta_pkg::ROT_TERMS)
                begin
                    cnt_next   = '0;
                    state_next = tta_pkg::ST_DONE;
                end
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            tta_pkg::ST_DONE:
            begin
                if (!status.out_valid || out_ready)
                begin
                    cmd.wb_sel = tta_pkg::WB_OUT;
                    state_next = tta_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tta_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/texture_transform_animator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_transform_animator: scroll and rotate texture matrix per time tick
//
// channel | modport | word
// tick    | sink    | time_delta, unsigned Q8.16 seconds
// mat     | source  | m00 m01 m03 m10 m11 m13, signed Q16.16
// cfg     | write   | cfg_we, cfg_index, cfg_data
//
// A tick's matrix word waits on the two 33-step reciprocal divisions, whose
// done flag is registered; the rotation terms and the load of the matrix
// word follow. No new tick is taken while one is in work. A new tick is
// taken once the matrix word is loaded, while that word waits.
// Reset clears scroll offsets and angle and loads register reset values.
// A stalled matrix word holds; the sequencer waits in its last step.
// ----------------------------------------------------------------------------
module texture_transform_animator (
    input  logic                           clk,
    input  logic                           rst_n,
    tta_tick_if.sink                       tick,
    tta_mat_if.source                      mat,
    input  logic                           cfg_we,
    input  logic [tta_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tta_pkg::CFG_DATA_W-1:0] cfg_data
);

    tta_pkg::dp_cmd_t    cmd;
    tta_pkg::dp_status_t status;

    tta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_ready  (tick.ready),
        .out_ready (mat.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tta_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .time_delta (tick.time_delta),
        .out_ready  (mat.ready),
        .m00        (mat.m00),
        .m01        (mat.m01),
        .m03        (mat.m03),
        .m10        (mat.m10),
        .m11        (mat.m11),
        .m13        (mat.m13)
    );

    assign mat.valid = status.out_valid;

endmodule

// File: rtl/tta_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_checker: port-level checks of the texture transform animator
// Handshake rules and sequencing seen at the top-level ports.
// ----------------------------------------------------------------------------
module tta_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               tick_valid,
    input logic               tick_ready,
    input logic               mat_valid,
    input logic               mat_ready,
    input logic signed [31:0] m00,
    input logic signed [31:0] m13
);

    a_mat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && !mat_ready |=> mat_valid)
        else $error("matrix word dropped while stalled");

    a_mat_stable: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && !mat_ready |=> $stable(m00) && $stable(m13))
        else $error("matrix word changed while stalled");

    a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("tick taken while busy");

    a_word_ready_next: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mat_valid) |-> tick_ready && !$past(tick_valid && tick_ready))
        else $error("matrix word out of sequence");

endmodule

bind texture_transform_animator tta_checker u_tta_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .mat_valid  (mat.valid),
    .mat_ready  (mat.ready),
    .m00        (mat.m00),
    .m13        (mat.m13)
);
